[sv/assert_macros.svh]
// assertion macros shared by the duration parser modules
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DSP_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DSP_ASSERT(label, clk, rst_n, ante, cons)
`define DSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/dsp_pkg.sv]
// types, character codes, slot codes and unit constants of the duration parser
// no dependencies
package dsp_pkg;

    localparam int DIGIT_W = 31;
    localparam int TOTAL_W = 63;
    localparam int USEC_W  = 25;
    localparam int PROD_W  = DIGIT_W + USEC_W;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = {DIGIT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_Y = 8'h59;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_S = 8'h53;

    typedef logic [3:0] t_slot;
    localparam t_slot SLOT_START = 4'd0;
    localparam t_slot SLOT_P     = 4'd1;
    localparam t_slot SLOT_Y     = 4'd2;
    localparam t_slot SLOT_MON   = 4'd3;
    localparam t_slot SLOT_D     = 4'd4;
    localparam t_slot SLOT_T     = 4'd5;
    localparam t_slot SLOT_H     = 4'd6;
    localparam t_slot SLOT_MIN   = 4'd7;
    localparam t_slot SLOT_S     = 4'd8;

    typedef enum logic [2:0] {
        UNIT_NONE   = 3'd0,
        UNIT_YEAR   = 3'd1,
        UNIT_MONTH  = 3'd2,
        UNIT_DAY    = 3'd3,
        UNIT_HOUR   = 3'd4,
        UNIT_MINUTE = 3'd5,
        UNIT_SECOND = 3'd6
    } t_unit;

    typedef struct packed {
        logic prefix;
        logic fully;
        logic dovf;
    } t_flags;

    typedef struct packed {
        logic [DIGIT_W-1:0] value;
        t_unit              unit;
        logic               last;
        t_flags             flags;
    } t_comp;

    // unit length in seconds
    function automatic logic [USEC_W-1:0] unit_sec(input t_unit u);
        logic [USEC_W-1:0] s;
        case (u)
            UNIT_YEAR:   s = USEC_W'(31556952);
            UNIT_MONTH:  s = USEC_W'(2629746);
            UNIT_DAY:    s = USEC_W'(86400);
            UNIT_HOUR:   s = USEC_W'(3600);
            UNIT_MINUTE: s = USEC_W'(60);
            UNIT_SECOND: s = USEC_W'(1);
            default:     s = '0;
        endcase
        return s;
    endfunction

endpackage

[sv/dsp_scan.sv]
// character scanner: grammar state, digit runs and component selection
// depends on dsp_pkg and assert_macros.svh
`include "assert_macros.svh"

module dsp_scan (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_char_in,
    input  logic          i_last_char,
    output dsp_pkg::t_comp o_comp
);

    dsp_pkg::t_slot                  r_slot, n_slot;
    logic                            r_stopped, n_stopped;
    logic                            r_prefix, n_prefix;
    logic [dsp_pkg::DIGIT_W-1:0]     r_digit, n_digit;
    logic                            r_pending, n_pending;
    logic                            r_dovf, n_dovf;

    logic [dsp_pkg::DIGIT_W+3:0]     nv;
    dsp_pkg::t_slot                  target;
    dsp_pkg::t_unit                  unit;
    dsp_pkg::t_unit                  sel_unit;
    logic                            time_part;
    logic                            known;

    always_comb begin
        n_slot    = r_slot;
        n_stopped = r_stopped;
        n_prefix  = r_prefix;
        n_digit   = r_digit;
        n_pending = r_pending;
        n_dovf    = r_dovf;
        sel_unit  = dsp_pkg::UNIT_NONE;
        target    = dsp_pkg::SLOT_START;
        unit      = dsp_pkg::UNIT_NONE;
        time_part = 1'b0;
        known     = 1'b1;
        nv        = {4'b0, r_digit} * (dsp_pkg::DIGIT_W+4)'(10)
                    + {{(dsp_pkg::DIGIT_W){1'b0}}, i_char_in[3:0]};

        case (i_char_in)
            dsp_pkg::CH_Y: begin
                target = dsp_pkg::SLOT_Y;
                unit   = dsp_pkg::UNIT_YEAR;
            end
            dsp_pkg::CH_D: begin
                target = dsp_pkg::SLOT_D;
                unit   = dsp_pkg::UNIT_DAY;
            end
            dsp_pkg::CH_H: begin
                target    = dsp_pkg::SLOT_H;
                unit      = dsp_pkg::UNIT_HOUR;
                time_part = 1'b1;
            end
            dsp_pkg::CH_S: begin
                target    = dsp_pkg::SLOT_S;
                unit      = dsp_pkg::UNIT_SECOND;
                time_part = 1'b1;
            end
            dsp_pkg::CH_M: begin
                if (r_slot < dsp_pkg::SLOT_T) begin
                    target = dsp_pkg::SLOT_MON;
                    unit   = dsp_pkg::UNIT_MONTH;
                end else begin
                    target    = dsp_pkg::SLOT_MIN;
                    unit      = dsp_pkg::UNIT_MINUTE;
                    time_part = 1'b1;
                end
            end
            default: begin
                known = 1'b0;
            end
        endcase

        if (!r_stopped) begin
            if (r_slot == dsp_pkg::SLOT_START) begin
                if (i_char_in == dsp_pkg::CH_P) begin
                    n_slot   = dsp_pkg::SLOT_P;
                    n_prefix = 1'b1;
                end else begin
                    n_stopped = 1'b1;
                end
            end else if (i_char_in inside {[dsp_pkg::CH_0:dsp_pkg::CH_9]}) begin
                if (nv > {4'b0, dsp_pkg::DIGIT_MAX}) begin
                    n_digit = dsp_pkg::DIGIT_MAX;
                    n_dovf  = 1'b1;
                end else begin
                    n_digit = nv[dsp_pkg::DIGIT_W-1:0];
                end
                n_pending = 1'b1;
            end else if (i_char_in == dsp_pkg::CH_T) begin
                if (!r_pending && r_slot <= dsp_pkg::SLOT_D) begin
                    n_slot = dsp_pkg::SLOT_T;
                end else begin
                    n_stopped = 1'b1;
                end
            end else if (!known || !r_pending || r_slot >= target
                         || (time_part ? r_slot < dsp_pkg::SLOT_T
                                       : r_slot >= dsp_pkg::SLOT_T)) begin
                n_stopped = 1'b1;
            end else begin
                sel_unit  = unit;
                n_slot    = target;
                n_digit   = '0;
                n_pending = 1'b0;
            end
        end

        o_comp.value        = r_digit;
        o_comp.unit         = sel_unit;
        o_comp.last         = i_last_char;
        o_comp.flags.prefix = n_prefix;
        o_comp.flags.fully  = n_prefix && !n_stopped && !n_pending;
        o_comp.flags.dovf   = n_dovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= dsp_pkg::SLOT_START;
            r_stopped <= 1'b0;
            r_prefix  <= 1'b0;
            r_digit   <= '0;
            r_pending <= 1'b0;
            r_dovf    <= 1'b0;
        end else if (i_accept) begin
            if (i_last_char) begin
                r_slot    <= dsp_pkg::SLOT_START;
                r_stopped <= 1'b0;
                r_prefix  <= 1'b0;
                r_digit   <= '0;
                r_pending <= 1'b0;
                r_dovf    <= 1'b0;
            end else begin
                r_slot    <= n_slot;
                r_stopped <= n_stopped;
                r_prefix  <= n_prefix;
                r_digit   <= n_digit;
                r_pending <= n_pending;
                r_dovf    <= n_dovf;
            end
        end
    end

    // token end returns everything to the start state
    `DSP_ASSERT_NEXT(a_scan_token_reset, i_clk, i_rst_n, i_accept && i_last_char,
        r_slot == dsp_pkg::SLOT_START && !r_stopped && !r_pending && r_digit == '0)
    // a digit run only follows the prefix
    `DSP_ASSERT(a_scan_pending_after_p, i_clk, i_rst_n, r_pending,
        r_prefix && r_slot != dsp_pkg::SLOT_START)
    // a component leaves only with pending digits and an accepted token
    `DSP_ASSERT(a_scan_comp_valid, i_clk, i_rst_n,
        i_accept && o_comp.unit != dsp_pkg::UNIT_NONE,
        r_pending && !r_stopped && r_prefix)

endmodule

[sv/dsp_accum.sv]
// component pipeline: multiply, scale to ms, saturating sum, result register
// depends on dsp_pkg and assert_macros.svh
`include "assert_macros.svh"

module dsp_accum (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_comp_valid,
    input  dsp_pkg::t_comp                i_comp,
    output logic                          o_comp_ready,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dsp_pkg::TOTAL_W-1:0]   o_duration_ms,
    output logic                          o_saw_prefix,
    output logic                          o_fully_matched,
    output logic                          o_overflow
);

    logic                            r_p1_valid;
    logic [dsp_pkg::DIGIT_W-1:0]     r_p1_value;
    dsp_pkg::t_unit                  r_p1_unit;
    logic                            r_p1_last;
    dsp_pkg::t_flags                 r_p1_flags;

    logic                            r_p2_valid;
    logic [dsp_pkg::PROD_W-1:0]      r_p2_prod;
    logic                            r_p2_last;
    dsp_pkg::t_flags                 r_p2_flags;

    logic                            r_p3_valid;
    logic [dsp_pkg::TOTAL_W-1:0]     r_p3_prod;
    logic                            r_p3_sat;
    logic                            r_p3_last;
    dsp_pkg::t_flags                 r_p3_flags;

    logic [dsp_pkg::TOTAL_W-1:0]     r_total, n_total;
    logic                            r_tovf, n_tovf;

    logic                            r_out_valid;
    logic [dsp_pkg::TOTAL_W-1:0]     r_out_ms;
    logic                            r_out_prefix;
    logic                            r_out_fully;
    logic                            r_out_ovf;

    logic [dsp_pkg::PROD_W-1:0]      n_p2_prod;
    logic [dsp_pkg::PROD_W+9:0]      prod_ms;
    logic [dsp_pkg::TOTAL_W:0]       sum;
    logic                            out_free, free1, free2, free3, leave3;

    assign out_free = !r_out_valid || i_out_ready;
    assign leave3   = r_p3_valid && (!r_p3_last || out_free);
    assign free3    = !r_p3_valid || leave3;
    assign free2    = !r_p2_valid || free3;
    assign free1    = !r_p1_valid || free2;
    assign o_comp_ready = free1;

    // seconds product, then ms = s * 1000 = s * 1024 - s * 24
    assign n_p2_prod = {{(dsp_pkg::PROD_W-dsp_pkg::DIGIT_W){1'b0}}, r_p1_value}
                       * {{(dsp_pkg::PROD_W-dsp_pkg::USEC_W){1'b0}},
                          dsp_pkg::unit_sec(r_p1_unit)};
    assign prod_ms   = {r_p2_prod, 10'b0} - {6'b0, r_p2_prod, 4'b0}
                       - {7'b0, r_p2_prod, 3'b0};
    assign sum       = {1'b0, r_total} + {1'b0, r_p3_prod};

    always_comb begin
        n_total = sum[dsp_pkg::TOTAL_W] ? dsp_pkg::TOTAL_MAX
                                        : sum[dsp_pkg::TOTAL_W-1:0];
        n_tovf  = r_tovf || sum[dsp_pkg::TOTAL_W] || r_p3_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            r_tovf      <= 1'b0;
        end else begin
            if (free1) begin
                r_p1_valid <= i_comp_valid;
            end
            if (free2) begin
                r_p2_valid <= r_p1_valid;
            end
            if (free3) begin
                r_p3_valid <= r_p2_valid;
            end
            if (out_free) begin
                r_out_valid <= leave3 && r_p3_last;
            end
            if (leave3) begin
                if (r_p3_last) begin
                    r_total <= '0;
                    r_tovf  <= 1'b0;
                end else begin
                    r_total <= n_total;
                    r_tovf  <= n_tovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free1 && i_comp_valid) begin
            r_p1_value <= i_comp.value;
            r_p1_unit  <= i_comp.unit;
            r_p1_last  <= i_comp.last;
            r_p1_flags <= i_comp.flags;
        end
        if (free2 && r_p1_valid) begin
            r_p2_prod  <= n_p2_prod;
            r_p2_last  <= r_p1_last;
            r_p2_flags <= r_p1_flags;
        end
        if (free3 && r_p2_valid) begin
            if (|prod_ms[dsp_pkg::PROD_W+9:dsp_pkg::TOTAL_W]) begin
                r_p3_prod <= dsp_pkg::TOTAL_MAX;
                r_p3_sat  <= 1'b1;
            end else begin
                r_p3_prod <= prod_ms[dsp_pkg::TOTAL_W-1:0];
                r_p3_sat  <= 1'b0;
            end
            r_p3_last  <= r_p2_last;
            r_p3_flags <= r_p2_flags;
        end
        if (out_free && leave3 && r_p3_last) begin
            r_out_ms     <= n_total;
            r_out_prefix <= r_p3_flags.prefix;
            r_out_fully  <= r_p3_flags.fully;
            r_out_ovf    <= n_tovf || r_p3_flags.dovf;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_duration_ms   = r_out_ms;
    assign o_saw_prefix    = r_out_prefix;
    assign o_fully_matched = r_out_fully;
    assign o_overflow      = r_out_ovf;

    // a finished token always lands in the result register
    `DSP_ASSERT_NEXT(a_acc_result_loaded, i_clk, i_rst_n, leave3 && r_p3_last, r_out_valid)
    // the running sum restarts after each token
    `DSP_ASSERT_NEXT(a_acc_sum_cleared, i_clk, i_rst_n, leave3 && r_p3_last,
        r_total == '0 && !r_tovf)
    // a saturated product is pinned at the maximum
    `DSP_ASSERT(a_acc_sat_max, i_clk, i_rst_n, r_p3_valid && r_p3_sat,
        r_p3_prod == dsp_pkg::TOTAL_MAX)

endmodule

[sv/duration_string_parser.sv]
// top level of the duration token parser, one character item per cycle unless held
// a token's last item passes stages p1, p2, p3, then loads the result register
// throughput: one character per cycle unless held, set by the scanner state loop
// the result register lets characters flow while a result waits, until stages fill
// reset: synchronous active-low, clears grammar state, pipeline valids and the sum
// depends on dsp_pkg, dsp_scan and dsp_accum
module duration_string_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_char_in,
    input  logic                          i_last_char,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dsp_pkg::TOTAL_W-1:0]   o_duration_ms,
    output logic                          o_saw_prefix,
    output logic                          o_fully_matched,
    output logic                          o_overflow
);

    dsp_pkg::t_comp comp;
    logic           accept;

    assign accept = i_in_valid && o_in_ready;

    dsp_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_in   (i_char_in),
        .i_last_char (i_last_char),
        .o_comp      (comp)
    );

    dsp_accum u_accum (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_comp_valid    (i_in_valid),
        .i_comp          (comp),
        .o_comp_ready    (o_in_ready),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_duration_ms   (o_duration_ms),
        .o_saw_prefix    (o_saw_prefix),
        .o_fully_matched (o_fully_matched),
        .o_overflow      (o_overflow)
    );

endmodule
